// File: src/hit_pkg.sv
// Shared types, widths and constants of the homography inlier test.
package hit_pkg;

   localparam int MAX_POINTS = 4096;
   localparam int CNT_W      = 13;
   localparam int CNT_LIMIT  = (1 << CNT_W) - 1;
   localparam logic [CNT_W-1:0] COUNT_CAP =
      CNT_W'((MAX_POINTS < CNT_LIMIT) ? MAX_POINTS : CNT_LIMIT);

   localparam int PT_W     = 20;
   localparam int COEF_W   = 32;
   localparam int PERSP_W  = 24;
   localparam int TOL_W    = 16;
   localparam int REQ_W    = 4 * PT_W;
   localparam int RSP_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 2 * PERSP_W;

   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 23;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int NUM_W   = 56;
   localparam int DEN_W   = 48;
   localparam int DIVD_W  = 64;
   localparam int DIVS_W  = 46;
   localparam int QUO_W   = 24;
   localparam int MAG_W   = 22;
   localparam int PROJ_W  = MAG_W + 1;
   localparam int ERR_W   = 24;
   localparam int ABS_W   = 22;
   localparam int DIST_W  = 45;
   localparam int TOL2_W  = 2 * TOL_W;
   localparam int CMP_W   = DIST_W + 8;
   localparam int STEP_W  = 5;

   // numerator carries 28 fraction bits, divisor 34: x1024 for 4 result bits, x2 for rounding
   localparam int NUM_SHIFT = 11;
   localparam int SHIFT_XY  = 16;
   localparam int W_ONE_BIT = 34;
   localparam logic [DEN_W-1:0] W_ONE     = DEN_W'(1) << W_ONE_BIT;
   localparam logic [MAG_W-1:0] CLAMP_MAG = MAG_W'(1) << (MAG_W - 1);

   localparam logic [CSR_IDX_W-1:0] REG_SCALE_XX  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHEAR_XY  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHEAR_YX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_YY  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PERSP     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ERR_TOL   = 3'd7;

   localparam logic [COEF_W-1:0] UNITY_RST   = 32'd16777216;
   localparam logic [TOL_W-1:0]  ERR_TOL_RST = 16'd768;

   typedef enum logic [3:0] {
      MUL_A_SX = 4'd0,
      MUL_B_SY = 4'd1,
      MUL_D_SX = 4'd2,
      MUL_E_SY = 4'd3,
      MUL_G_SX = 4'd4,
      MUL_H_SY = 4'd5,
      MUL_EX   = 4'd6,
      MUL_EY   = 4'd7,
      MUL_TOL  = 4'd8
   } mul_op_type;

   localparam int MAP_OPS = 6;
   localparam int SQR_OPS = 3;
   localparam int DIV_BITS = QUO_W;

   typedef struct packed {
      logic signed [COEF_W-1:0]  scale_xx;
      logic signed [COEF_W-1:0]  shear_xy;
      logic signed [COEF_W-1:0]  shift_x;
      logic signed [COEF_W-1:0]  shear_yx;
      logic signed [COEF_W-1:0]  scale_yy;
      logic signed [COEF_W-1:0]  shift_y;
      logic signed [PERSP_W-1:0] persp_g;
      logic signed [PERSP_W-1:0] persp_h;
      logic [TOL_W-1:0]          err_tol;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      mul_op_type mul_op;
      logic       div_start;
      logic       div_y;
      logic       div_step;
      logic       div_store;
      logic       abs_en;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic out_stall;
   } sts_type;

endpackage

// File: src/homography_inlier_test.sv
// Top level of the homography inlier test: registers, sequencer and datapath.
//
//  channel  dir  beat fields (tdata low bit up)             sideband
//  req_     in   src_x, src_y, dst_x, dst_y (20b signed)    tlast = last_pair
//  rsp_     out  inlier, inlier_count (13b), 2 pad bits     tlast = last_out
//  csr_     in   csr_index 0..7, csr_data (48b)             always ready
//
// The next pair is taken only once the last has finished: the shared
// restoring divider produces one quotient bit a cycle, 24 bits for each of x and y.
// Six multiply beats before, three after, all on one 32x23 multiplier.
// Reset is synchronous; registers return to identity matrix, tolerance 3.0 px.
// A finished result waits in the output register; a new pair is taken meanwhile
// and holds only at its final cycle until that beat has gone.
module homography_inlier_test
   import hit_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // src_x, src_y, dst_x, dst_y
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // inlier, inlier_count, zero pad
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   hit_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hit_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: src/hit_regs.sv
// Configuration register file: matrix entries and tolerance.
module hit_regs
   import hit_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_xx <= UNITY_RST;
         cfg_ff.shear_xy <= '0;
         cfg_ff.shift_x  <= '0;
         cfg_ff.shear_yx <= '0;
         cfg_ff.scale_yy <= UNITY_RST;
         cfg_ff.shift_y  <= '0;
         cfg_ff.persp_g  <= '0;
         cfg_ff.persp_h  <= '0;
         cfg_ff.err_tol  <= ERR_TOL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SCALE_XX: cfg_ff.scale_xx <= csr_data[COEF_W-1:0];
            REG_SHEAR_XY: cfg_ff.shear_xy <= csr_data[COEF_W-1:0];
            REG_SHIFT_X:  cfg_ff.shift_x  <= csr_data[COEF_W-1:0];
            REG_SHEAR_YX: cfg_ff.shear_yx <= csr_data[COEF_W-1:0];
            REG_SCALE_YY: cfg_ff.scale_yy <= csr_data[COEF_W-1:0];
            REG_SHIFT_Y:  cfg_ff.shift_y  <= csr_data[COEF_W-1:0];
            REG_PERSP: begin
               cfg_ff.persp_g <= csr_data[2*PERSP_W-1:PERSP_W];
               cfg_ff.persp_h <= csr_data[PERSP_W-1:0];
            end
            REG_ERR_TOL:  cfg_ff.err_tol  <= csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

// File: src/hit_ctrl.sv
// Sequencer: steps the shared multiplier, divider and result stage for one pair.
module hit_ctrl
   import hit_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_MUL       = 10'b00_0000_0010,
      ST_MUL_DRAIN = 10'b00_0000_0100,
      ST_DIV_INIT  = 10'b00_0000_1000,
      ST_DIV_RUN   = 10'b00_0001_0000,
      ST_DIV_END   = 10'b00_0010_0000,
      ST_ABS       = 10'b00_0100_0000,
      ST_SQR       = 10'b00_1000_0000,
      ST_SQR_DRAIN = 10'b01_0000_0000,
      ST_DONE      = 10'b10_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              div_y_ff, div_y_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      div_y_in      = div_y_ff;
      cmd           = '0;
      cmd.mul_op    = MUL_A_SX;
      cmd.div_y     = div_y_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = mul_op_type'(step_ff[3:0]);
            step_in    = step_ff + 1'b1;
            if (step_ff == STEP_W'(MAP_OPS - 1)) begin
               state_in = ST_MUL_DRAIN;
            end
         end
         ST_MUL_DRAIN: begin
            div_y_in = 1'b0;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_start = 1'b1;
            step_in       = '0;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_BITS - 1)) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            cmd.div_store = 1'b1;
            if (div_y_ff) begin
               state_in = ST_ABS;
            end else begin
               div_y_in = 1'b1;
               state_in = ST_DIV_INIT;
            end
         end
         ST_ABS: begin
            cmd.abs_en = 1'b1;
            step_in    = '0;
            state_in   = ST_SQR;
         end
         ST_SQR: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = mul_op_type'(4'(MUL_EX) + step_ff[3:0]);
            step_in    = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQR_OPS - 1)) begin
               state_in = ST_SQR_DRAIN;
            end
         end
         ST_SQR_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.out_stall) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         div_y_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         div_y_ff <= div_y_in;
      end
   end

endmodule

// File: src/hit_dp.sv
// Datapath: shared multiplier, accumulators, restoring divider, distance test, count.
module hit_dp
   import hit_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   logic signed [PT_W-1:0]   src_x_ff, src_y_ff, dst_x_ff, dst_y_ff;
   logic                     last_ff;

   logic signed [NUM_W-1:0]  nx_ff, ny_ff;
   logic signed [DEN_W-1:0]  w_ff;

   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [PROD_W-1:0]  prod_ff;
   mul_op_type                op_ff;
   logic                      prod_vld_ff;
   logic signed [NUM_W-1:0]   prod_ext;

   logic [NUM_W-1:0]    n_sel, n_mag;
   logic [DEN_W-1:0]    d_mag;
   logic [DIVD_W-1:0]   dvd;
   logic [DIVS_W-1:0]   dvs_n;
   logic                ovf_n;
   logic [DIVS_W-1:0]   rem_ff, dvs_ff;
   logic [QUO_W-1:0]    dvd_lo_ff, quo_ff;
   logic                neg_ff, ovf_ff, zero_ff;
   logic [DIVS_W:0]     trial, diff;
   logic                ge;
   logic [MAG_W-1:0]    mag;
   logic [PROJ_W-1:0]   proj;
   logic [PROJ_W-1:0]   px_ff, py_ff;

   logic [ERR_W-1:0]    ex, ey, ex_mag, ey_mag;
   logic [ABS_W-1:0]    ux_ff, uy_ff;
   logic [DIST_W-1:0]   dist_ff;
   logic [TOL2_W-1:0]   tol2_ff;

   logic                inl;
   logic [CNT_W-1:0]    cnt_next, count_ff;
   logic                rsp_valid_ff, rsp_inl_ff, rsp_last_ff;
   logic [CNT_W-1:0]    rsp_cnt_ff;

   // multiplier operands
   always_comb begin
      unique case (cmd.mul_op)
         MUL_A_SX: begin
            op_a = cfg.scale_xx;
            op_b = {{(MUL_B_W-PT_W){src_x_ff[PT_W-1]}}, src_x_ff};
         end
         MUL_B_SY: begin
            op_a = cfg.shear_xy;
            op_b = {{(MUL_B_W-PT_W){src_y_ff[PT_W-1]}}, src_y_ff};
         end
         MUL_D_SX: begin
            op_a = cfg.shear_yx;
            op_b = {{(MUL_B_W-PT_W){src_x_ff[PT_W-1]}}, src_x_ff};
         end
         MUL_E_SY: begin
            op_a = cfg.scale_yy;
            op_b = {{(MUL_B_W-PT_W){src_y_ff[PT_W-1]}}, src_y_ff};
         end
         MUL_G_SX: begin
            op_a = {{(MUL_A_W-PERSP_W){cfg.persp_g[PERSP_W-1]}}, cfg.persp_g};
            op_b = {{(MUL_B_W-PT_W){src_x_ff[PT_W-1]}}, src_x_ff};
         end
         MUL_H_SY: begin
            op_a = {{(MUL_A_W-PERSP_W){cfg.persp_h[PERSP_W-1]}}, cfg.persp_h};
            op_b = {{(MUL_B_W-PT_W){src_y_ff[PT_W-1]}}, src_y_ff};
         end
         MUL_EX: begin
            op_a = {{(MUL_A_W-ABS_W){1'b0}}, ux_ff};
            op_b = {{(MUL_B_W-ABS_W){1'b0}}, ux_ff};
         end
         MUL_EY: begin
            op_a = {{(MUL_A_W-ABS_W){1'b0}}, uy_ff};
            op_b = {{(MUL_B_W-ABS_W){1'b0}}, uy_ff};
         end
         MUL_TOL: begin
            op_a = {{(MUL_A_W-TOL_W){1'b0}}, cfg.err_tol};
            op_b = {{(MUL_B_W-TOL_W){1'b0}}, cfg.err_tol};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_ext = {{(NUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // divider set-up: magnitudes, x2048 numerator plus divisor for round-half-up
   always_comb begin
      n_sel = cmd.div_y ? ny_ff : nx_ff;
      n_mag = n_sel[NUM_W-1] ? (~n_sel + NUM_W'(1)) : n_sel;
      d_mag = w_ff[DEN_W-1] ? (~w_ff + DEN_W'(1)) : w_ff;
      dvd   = (DIVD_W'(n_mag) << NUM_SHIFT) + DIVD_W'(d_mag);
      dvs_n = {d_mag[DIVS_W-2:0], 1'b0};
      ovf_n = DIVS_W'(dvd[DIVD_W-1:QUO_W]) >= dvs_n;
   end

   // one quotient bit per beat of the step command
   always_comb begin
      trial = {rem_ff, dvd_lo_ff[QUO_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      if (ovf_ff || (quo_ff > QUO_W'(CLAMP_MAG))) begin
         mag = CLAMP_MAG;
      end else begin
         mag = quo_ff[MAG_W-1:0];
      end
      if (zero_ff) begin
         proj = '0;
      end else if (neg_ff) begin
         proj = ~{1'b0, mag} + PROJ_W'(1);
      end else begin
         proj = {1'b0, mag};
      end
   end

   always_comb begin
      ex     = {{(ERR_W-PT_W){dst_x_ff[PT_W-1]}}, dst_x_ff} - {px_ff[PROJ_W-1], px_ff};
      ey     = {{(ERR_W-PT_W){dst_y_ff[PT_W-1]}}, dst_y_ff} - {py_ff[PROJ_W-1], py_ff};
      ex_mag = ex[ERR_W-1] ? (~ex + ERR_W'(1)) : ex;
      ey_mag = ey[ERR_W-1] ? (~ey + ERR_W'(1)) : ey;
   end

   always_comb begin
      inl = {dist_ff, 8'b0} <= CMP_W'(tol2_ff);
      if (inl && (count_ff < COUNT_CAP)) begin
         cnt_next = count_ff + 1'b1;
      end else begin
         cnt_next = count_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_x_ff <= req_tdata[PT_W-1:0];
         src_y_ff <= req_tdata[2*PT_W-1:PT_W];
         dst_x_ff <= req_tdata[3*PT_W-1:2*PT_W];
         dst_y_ff <= req_tdata[4*PT_W-1:3*PT_W];
         last_ff  <= req_tlast;
         nx_ff    <= {{(NUM_W-COEF_W-SHIFT_XY){cfg.shift_x[COEF_W-1]}},
                      cfg.shift_x, {SHIFT_XY{1'b0}}};
         ny_ff    <= {{(NUM_W-COEF_W-SHIFT_XY){cfg.shift_y[COEF_W-1]}},
                      cfg.shift_y, {SHIFT_XY{1'b0}}};
         w_ff     <= W_ONE;
      end else if (prod_vld_ff) begin
         case (op_ff) inside
            MUL_A_SX, MUL_B_SY: nx_ff <= nx_ff + prod_ext;
            MUL_D_SX, MUL_E_SY: ny_ff <= ny_ff + prod_ext;
            MUL_G_SX, MUL_H_SY: w_ff  <= w_ff + prod_ff[DEN_W-1:0];
            default: ;
         endcase
      end

      prod_ff <= op_a * op_b;
      op_ff   <= cmd.mul_op;

      if (prod_vld_ff) begin
         case (op_ff)
            MUL_EX:  dist_ff <= prod_ff[DIST_W-1:0];
            MUL_EY:  dist_ff <= dist_ff + prod_ff[DIST_W-1:0];
            MUL_TOL: tol2_ff <= prod_ff[TOL2_W-1:0];
            default: ;
         endcase
      end

      if (cmd.div_start) begin
         neg_ff    <= n_sel[NUM_W-1] ^ w_ff[DEN_W-1];
         zero_ff   <= (w_ff == '0);
         ovf_ff    <= ovf_n;
         dvs_ff    <= dvs_n;
         rem_ff    <= DIVS_W'(dvd[DIVD_W-1:QUO_W]);
         dvd_lo_ff <= dvd[QUO_W-1:0];
         quo_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff    <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
         dvd_lo_ff <= {dvd_lo_ff[QUO_W-2:0], 1'b0};
         quo_ff    <= {quo_ff[QUO_W-2:0], ge};
      end

      if (cmd.div_store) begin
         if (cmd.div_y) begin
            py_ff <= proj;
         end else begin
            px_ff <= proj;
         end
      end

      if (cmd.abs_en) begin
         ux_ff <= ex_mag[ABS_W-1:0];
         uy_ff <= ey_mag[ABS_W-1:0];
      end

      if (cmd.finish) begin
         rsp_inl_ff  <= inl;
         rsp_cnt_ff  <= cnt_next;
         rsp_last_ff <= last_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul_en;
         if (cmd.finish) begin
            count_ff     <= last_ff ? '0 : cnt_next;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.out_stall = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = {{(RSP_W-CNT_W-1){1'b0}}, rsp_cnt_ff, rsp_inl_ff};
   assign rsp_tlast     = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !sts.out_stall)
      else $error("result written over an untaken beat");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_CAP)
      else $error("inlier count above cap");

   a_set_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && last_ff) |=> (count_ff == '0))
      else $error("count not cleared after last pair");

   a_rsp_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_tvalid && (rsp_tdata[CNT_W:1] == $past(cnt_next))))
      else $error("result beat not presented");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for homography_inlier_test with a bit-exact predictor.
`timescale 1ns / 1ps

module testbench;
   import hit_pkg::*;

   typedef logic signed [PT_W-1:0] coord_type;

   typedef struct packed {
      logic      last_pair;
      coord_type dst_y;
      coord_type dst_x;
      coord_type src_y;
      coord_type src_x;
   } pair_type;

   typedef struct packed {
      logic             last_out;
      logic [CNT_W-1:0] count;
      logic             inlier;
   } verdict_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam coord_type   PT_MAX      = coord_type'(524287);
   localparam coord_type   PT_MIN      = coord_type'(-524288);
   localparam logic [63:0] PROJ_LIMIT  = 64'd2097152;
   localparam int          HOLD_CYCLES = 800;
   localparam int          LONG_PAIRS  = 100;
   localparam int          END_CYCLES  = 200;
   localparam longint      CYCLE_LIMIT = 500000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   pair_type    pairs_to_send[$];
   verdict_type awaited_verdicts[$];
   cfg_type     model_cfg;
   logic [CNT_W-1:0] set_count = '0;

   int     req_beats       = 0;
   int     req_launched    = 0;
   int     send_idle_pct   = 0;
   int     rsp_stall_pct   = 0;
   bit     hold_request    = 1'b0;
   bit     hold_active     = 1'b0;
   longint cycles          = 0;
   int     mismatches      = 0;
   int     results_seen    = 0;
   int     inliers_seen    = 0;
   int     peak_count      = 0;
   int     settings_loaded = 0;

   homography_inlier_test i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
   endtask

   // quotient with 4 fraction bits, nearest with ties away from zero, clamped
   function automatic longint map_axis(longint num, longint den);
      logic [63:0] mag_n, mag_d, q;
      if (den == 0)
         return 0;
      mag_n = (num < 0) ? -num : num;
      mag_d = (den < 0) ? -den : den;
      q = ((mag_n << 11) + mag_d) / (mag_d << 1);
      if (q > PROJ_LIMIT)
         q = PROJ_LIMIT;
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic void project_point(coord_type sx, coord_type sy,
                                         output longint px, output longint py);
      longint x, y, nx, ny, w;
      x  = longint'(sx);
      y  = longint'(sy);
      nx = longint'($signed(model_cfg.scale_xx)) * x + longint'($signed(model_cfg.shear_xy)) * y
         + longint'($signed(model_cfg.shift_x)) * 65536;
      ny = longint'($signed(model_cfg.shear_yx)) * x + longint'($signed(model_cfg.scale_yy)) * y
         + longint'($signed(model_cfg.shift_y)) * 65536;
      w  = longint'($signed(model_cfg.persp_g)) * x + longint'($signed(model_cfg.persp_h)) * y
         + (longint'(1) << 34);
      px = map_axis(nx, w);
      py = map_axis(ny, w);
   endfunction

   function automatic verdict_type judge_pair(pair_type p);
      verdict_type v;
      longint      px, py, ex, ey, dist2, tol2;
      project_point(p.src_x, p.src_y, px, py);
      ex = longint'(p.dst_x) - px;
      ey = longint'(p.dst_y) - py;
      if (ex < 0)
         ex = -ex;
      if (ey < 0)
         ey = -ey;
      dist2 = (ex * ex + ey * ey) * 256;
      tol2  = longint'(model_cfg.err_tol) * longint'(model_cfg.err_tol);
      v.inlier = (dist2 <= tol2);
      if (v.inlier && set_count < COUNT_CAP)
         set_count++;
      v.count    = set_count;
      v.last_out = p.last_pair;
      if (p.last_pair)
         set_count = '0;
      return v;
   endfunction

   always @(negedge clock) begin : pair_driver
      pair_type p;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_beats == req_launched) begin
         if (pairs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            p = pairs_to_send.pop_front();
            req_tvalid   <= 1'b1;
            req_tdata    <= {p.dst_y, p.dst_x, p.src_y, p.src_x};
            req_tlast    <= p.last_pair;
            req_launched <= req_launched + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !hold_active && ($urandom_range(99) >= rsp_stall_pct);
   end

   // long output hold-off, timed here while the sender keeps offering
   initial begin
      wait (hold_request);
      @(posedge clock);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   always @(posedge clock) begin : beat_monitor
      pair_type    got;
      verdict_type want;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (awaited_verdicts.size() == 0) begin
               flag_mismatch($sformatf("result beat %0d with nothing outstanding", results_seen));
            end else begin
               want = awaited_verdicts.pop_front();
               if (rsp_tdata[0] !== want.inlier)
                  flag_mismatch($sformatf("beat %0d inlier: got %b, want %b",
                                          results_seen, rsp_tdata[0], want.inlier));
               if (rsp_tdata[CNT_W:1] !== want.count)
                  flag_mismatch($sformatf("beat %0d inlier_count: got %0d, want %0d",
                                          results_seen, rsp_tdata[CNT_W:1], want.count));
               if (rsp_tlast !== want.last_out)
                  flag_mismatch($sformatf("beat %0d last_out: got %b, want %b",
                                          results_seen, rsp_tlast, want.last_out));
               if (want.inlier)
                  inliers_seen++;
               if (int'(want.count) > peak_count)
                  peak_count = int'(want.count);
            end
         end
         if (req_tvalid && req_tready) begin
            got.src_x     = req_tdata[PT_W-1:0];
            got.src_y     = req_tdata[2*PT_W-1:PT_W];
            got.dst_x     = req_tdata[3*PT_W-1:2*PT_W];
            got.dst_y     = req_tdata[4*PT_W-1:3*PT_W];
            got.last_pair = req_tlast;
            awaited_verdicts.insert(awaited_verdicts.size(), judge_pair(got));
            req_beats <= req_beats + 1;
         end
      end
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("timed out after %0d cycles, %0d results outstanding",
               cycles, awaited_verdicts.size());
      $display("[homography_inlier_test] ERROR");
      $finish;
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_SCALE_XX: model_cfg.scale_xx = value[COEF_W-1:0];
         REG_SHEAR_XY: model_cfg.shear_xy = value[COEF_W-1:0];
         REG_SHIFT_X:  model_cfg.shift_x  = value[COEF_W-1:0];
         REG_SHEAR_YX: model_cfg.shear_yx = value[COEF_W-1:0];
         REG_SCALE_YY: model_cfg.scale_yy = value[COEF_W-1:0];
         REG_SHIFT_Y:  model_cfg.shift_y  = value[COEF_W-1:0];
         REG_PERSP: begin
            model_cfg.persp_g = value[2*PERSP_W-1:PERSP_W];
            model_cfg.persp_h = value[PERSP_W-1:0];
         end
         REG_ERR_TOL:  model_cfg.err_tol  = value[TOL_W-1:0];
         default: ;
      endcase
   endtask

   // unused upper data bits carry junk, which the block must drop
   task automatic load_setting(cfg_type s);
      logic [31:0] junk;
      junk = $urandom;
      csr_write(REG_SCALE_XX, {junk[15:0], s.scale_xx});
      csr_write(REG_SHEAR_XY, {junk[31:16], s.shear_xy});
      csr_write(REG_SHIFT_X,  {junk[23:8], s.shift_x});
      csr_write(REG_SHEAR_YX, {junk[15:0], s.shear_yx});
      csr_write(REG_SCALE_YY, {junk[31:16], s.scale_yy});
      csr_write(REG_SHIFT_Y,  {junk[23:8], s.shift_y});
      csr_write(REG_PERSP,    {s.persp_g, s.persp_h});
      csr_write(REG_ERR_TOL,  {junk, s.err_tol});
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic pick_setting(output cfg_type s);
      int kind;
      kind = $urandom_range(3);
      s = '0;
      case (kind)
         2: begin
            s.scale_xx = $urandom;
            s.shear_xy = $urandom;
            s.shift_x  = $urandom;
            s.shear_yx = $urandom;
            s.scale_yy = $urandom;
            s.shift_y  = $urandom;
            s.persp_g  = 24'($urandom);
            s.persp_h  = 24'($urandom);
         end
         3: begin
            // coarse steps so that half-unit ties turn up
            s.scale_xx = 32'(($urandom_range(16) - 8) << 23);
            s.shear_xy = 32'(($urandom_range(16) - 8) << 22);
            s.shift_x  = 32'(($urandom_range(4096) - 2048) << 7);
            s.shear_yx = 32'(($urandom_range(16) - 8) << 22);
            s.scale_yy = 32'(($urandom_range(16) - 8) << 23);
            s.shift_y  = 32'(($urandom_range(4096) - 2048) << 7);
         end
         default: begin
            s.scale_xx = 32'(16777216 + $urandom_range(8388608) - 4194304);
            s.shear_xy = 32'($urandom_range(4194304) - 2097152);
            s.shift_x  = 32'($urandom_range(4194304) - 2097152);
            s.shear_yx = 32'($urandom_range(4194304) - 2097152);
            s.scale_yy = 32'(16777216 + $urandom_range(8388608) - 4194304);
            s.shift_y  = 32'($urandom_range(4194304) - 2097152);
            if (kind == 1) begin
               s.persp_g = 24'($urandom_range(16384) - 8192);
               s.persp_h = 24'($urandom_range(16384) - 8192);
            end
         end
      endcase
      case ($urandom_range(9))
         0:       s.err_tol = '0;
         1:       s.err_tol = '1;
         2:       s.err_tol = 16'($urandom);
         default: s.err_tol = 16'($urandom_range(2047));
      endcase
   endtask

   task automatic set_idling(idle_mode_type m);
      case (m)
         IDLE_SENDER:   begin send_idle_pct = 46; rsp_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  rsp_stall_pct = 46; end
         IDLE_BOTH:     begin send_idle_pct = 11; rsp_stall_pct = 11; end
         default:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
      endcase
   endtask

   task automatic queue_pair(coord_type sx, coord_type sy, coord_type dx, coord_type dy,
                             logic lastp);
      pair_type p;
      p.src_x     = sx;
      p.src_y     = sy;
      p.dst_x     = dx;
      p.dst_y     = dy;
      p.last_pair = lastp;
      pairs_to_send.insert(pairs_to_send.size(), p);
   endtask

   function automatic coord_type fit_coord(longint v);
      if (v > longint'(PT_MAX))
         return PT_MAX;
      if (v < longint'(PT_MIN))
         return PT_MIN;
      return coord_type'(v);
   endfunction

   function automatic coord_type corner_coord();
      case ($urandom_range(3))
         0:       return PT_MIN;
         1:       return PT_MAX;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // mostly pairs near the projection, straddling the tolerance
   task automatic queue_pair_set(int len);
      coord_type sx, sy, dx, dy;
      longint    px, py;
      int        span, off_x, off_y, pick;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            if ($urandom_range(4) == 0) begin
               sx = coord_type'($urandom);
               sy = coord_type'($urandom);
            end else begin
               sx = coord_type'($urandom_range(65535) - 32768);
               sy = coord_type'($urandom_range(65535) - 32768);
            end
            project_point(sx, sy, px, py);
            span  = model_cfg.err_tol / 16 + 3;
            off_x = int'($urandom_range(2 * span)) - span;
            off_y = int'($urandom_range(2 * span)) - span;
            dx = fit_coord(px + off_x);
            dy = fit_coord(py + off_y);
         end else if (pick < 85) begin
            sx = coord_type'($urandom);
            sy = coord_type'($urandom);
            dx = coord_type'($urandom);
            dy = coord_type'($urandom);
         end else begin
            sx = corner_coord();
            sy = corner_coord();
            dx = corner_coord();
            dy = corner_coord();
         end
         queue_pair(sx, sy, dx, dy, i == len - 1);
      end
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
      end while (pairs_to_send.size() != 0 || req_tvalid || awaited_verdicts.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      cfg_type   s;
      int        queued, len;
      coord_type sx;

      model_cfg          = '0;
      model_cfg.scale_xx = UNITY_RST;
      model_cfg.scale_yy = UNITY_RST;
      model_cfg.err_tol  = ERR_TOL_RST;
      set_idling(IDLE_NONE);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset matrix is identity, tolerance 3 px
      queue_pair(0, 0, 0, 0, 1'b0);
      queue_pair(1600, -3200, 1648, -3200, 1'b0);
      queue_pair(1600, -3200, 1649, -3200, 1'b0);
      queue_pair(-50, 70, -17, 104, 1'b0);
      queue_pair(-50, 70, -16, 104, 1'b0);
      queue_pair(PT_MAX, PT_MAX, PT_MAX, PT_MAX, 1'b0);
      queue_pair(PT_MIN, PT_MIN, PT_MIN, PT_MIN, 1'b0);
      queue_pair(PT_MAX, PT_MIN, PT_MIN, PT_MAX, 1'b1);
      queue_pair(5, 5, 900, -900, 1'b1);
      drain();

      // divisor zero at sx = 2048, negative beyond, zero tolerance
      s          = '0;
      s.scale_xx = UNITY_RST;
      s.scale_yy = 32'h0080_0000;
      s.persp_g  = 24'h80_0000;
      load_setting(s);
      queue_pair(2048, 777, 0, 0, 1'b0);
      queue_pair(4096, 100, -4096, -50, 1'b0);
      queue_pair(0, 1, 0, 1, 1'b0);
      queue_pair(0, -1, 0, -1, 1'b0);
      queue_pair(0, 3, 0, 2, 1'b0);
      queue_pair(2047, 2047, PT_MAX, PT_MAX, 1'b0);
      queue_pair(2049, 0, PT_MIN, 0, 1'b1);
      drain();

      s.scale_xx = 32'h7FFF_FFFF;
      s.shear_xy = 32'h8000_0000;
      s.shift_x  = 32'h7FFF_FFFF;
      s.shear_yx = 32'h8000_0000;
      s.scale_yy = 32'h7FFF_FFFF;
      s.shift_y  = 32'h8000_0000;
      s.persp_g  = 24'h7F_FFFF;
      s.persp_h  = 24'h80_0000;
      s.err_tol  = '1;
      load_setting(s);
      queue_pair(PT_MAX, PT_MAX, PT_MIN, PT_MIN, 1'b0);
      queue_pair(PT_MIN, PT_MAX, PT_MAX, PT_MIN, 1'b0);
      queue_pair(0, 0, PT_MAX, PT_MAX, 1'b0);
      queue_pair(-1, -1, 0, 0, 1'b1);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         pick_setting(s);
         load_setting(s);
         set_idling(idle_mode_type'(ph % 4));
         if (ph == 4)
            hold_request = 1'b1;
         queued = 0;
         while (queued < 80) begin
            len = $urandom_range(1, 40);
            queue_pair_set(len);
            queued += len;
         end
         drain();
      end

      // one long set of exact matches, every pair an inlier
      s          = '0;
      s.scale_xx = UNITY_RST;
      s.scale_yy = UNITY_RST;
      s.err_tol  = ERR_TOL_RST;
      load_setting(s);
      set_idling(IDLE_NONE);
      for (int i = 0; i < LONG_PAIRS; i++) begin
         sx = coord_type'($urandom);
         queue_pair(sx, ~sx, sx, ~sx, i == LONG_PAIRS - 1);
      end
      drain();

      repeat (END_CYCLES) @(posedge clock);
      if (awaited_verdicts.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", awaited_verdicts.size()));
      $display("checked %0d result beats (%0d inliers, peak count %0d) over %0d matrix settings",
               results_seen, inliers_seen, peak_count, settings_loaded);
      $display("covered zero and negative divisors, clamping, ties, idling, a %0d-cycle hold-off",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("[homography_inlier_test] OK");
      end else begin
         $display("[homography_inlier_test] ERROR");
      end
      $finish;
   end

endmodule
